// ===== hw/rtl/utf16_to_utf32_decoder_top_defines.svh =====
// Assertion macros for the UTF-16 to UTF-32 decoder.
// Included by files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef UTF16_TO_UTF32_DECODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF32_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define UTFD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf16 decoder: implication check failed");
// The condition must never be seen at a clock edge.
`define UTFD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("utf16 decoder: forbidden condition seen");
`else
`define UTFD_ASSERT_IMPLY(lbl, ante, cons)
`define UTFD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== hw/rtl/utfd_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-32 decoder.
// No dependencies; used by every module of the block.
package utfd_pkg;

    // Stop reasons reported on the final result of a buffer.
    typedef enum logic [2:0] {
        STOP_NONE,
        STOP_UNPAIRED_HIGH,
        STOP_HIGH_AT_END,
        STOP_LONE_LOW,
        STOP_OUTPUT_FULL
    } stop_t;

    // Configuration register indexes.
    localparam logic REG_IGNORE_ERRORS = 1'b0;
    localparam logic REG_OUTPUT_LIMIT  = 1'b1;

    // Surrogate classification: top six bits of a code unit.
    localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SUR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    localparam int CNT_W = 17;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One result item.
    typedef struct packed {
        logic [20:0]      code_point;
        logic             has_code_point;
        logic             done_res;
        stop_t            stop_reason;
        logic [CNT_W-1:0] produced_count;
        logic [CNT_W-1:0] consumed_count;
        logic             last_of_run;
    } res_t;

    // All results caused by one input item (one or two).
    typedef struct packed {
        res_t first;
        res_t second;
        logic two;
    } rec_t;

endpackage

// ===== hw/rtl/utfd_front.sv =====
// Front part: accepts code units, tracks surrogate and buffer state, and
// builds the result record of each item. Depends on utfd_pkg.
module utfd_front #(
    parameter int MAX_UNITS = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [15:0]         code_unit,
    input  logic                end_of_buffer,
    input  logic                ignore_errors,
    input  logic [16:0]         output_limit,
    output logic                push,
    output utfd_pkg::rec_t      push_rec
);
    import utfd_pkg::*;

    localparam logic [CNT_W-1:0] CntCap =
        (MAX_UNITS < 131071) ? CNT_W'(MAX_UNITS) : {CNT_W{1'b1}};

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CntCap) ? v + 1'b1 : v;
    endfunction

    logic             pend_reg, pend_next;
    logic [9:0]       phigh_reg, phigh_next;
    logic             stopped_reg, stopped_next;
    stop_t            scode_reg, scode_next;
    logic [CNT_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0] cons_reg, cons_next;

    logic       u_high, u_low, do_fresh, lim_on;
    logic [1:0] n;
    res_t       r0, r1, rn;
    logic [20:0] cp_pair;

    assign u_high  = (code_unit[15:10] == SUR_HIGH_TAG);
    assign u_low   = (code_unit[15:10] == SUR_LOW_TAG);
    assign lim_on  = (output_limit != '0);
    assign cp_pair = {1'b0, phigh_reg, code_unit[9:0]} + SUPP_BASE;

    // Decode one item: up to one combined or passed-through surrogate, then
    // the unit on its own, then the end-of-buffer summary.
    always_comb begin
        pend_next    = pend_reg;
        phigh_next   = phigh_reg;
        stopped_next = stopped_reg;
        scode_next   = scode_reg;
        prod_next    = prod_reg;
        cons_next    = cons_reg;
        n            = 2'd0;
        r0           = '0;
        r1           = '0;
        rn           = '0;
        do_fresh     = 1'b0;

        if (!stopped_reg) begin
            if (pend_reg) begin
                if (u_low) begin
                    // Pending high plus this low form a supplementary code point.
                    cons_next = sat_inc(cons_reg);
                    pend_next = 1'b0;
                    if (lim_on && prod_next >= output_limit) begin
                        stopped_next = 1'b1;
                        scode_next   = STOP_OUTPUT_FULL;
                    end else begin
                        prod_next         = sat_inc(prod_next);
                        r0.code_point     = cp_pair;
                        r0.has_code_point = 1'b1;
                        r0.produced_count = prod_next;
                        r0.consumed_count = cons_next;
                        n                 = 2'd1;
                    end
                end else if (!ignore_errors) begin
                    stopped_next = 1'b1;
                    scode_next   = STOP_UNPAIRED_HIGH;
                    pend_next    = 1'b0;
                end else begin
                    // Lenient: the unpaired high goes out as is.
                    pend_next = 1'b0;
                    if (lim_on && prod_next >= output_limit) begin
                        stopped_next = 1'b1;
                        scode_next   = STOP_OUTPUT_FULL;
                    end else begin
                        prod_next         = sat_inc(prod_next);
                        r0.code_point     = {5'b0, SUR_HIGH_TAG, phigh_reg};
                        r0.has_code_point = 1'b1;
                        r0.produced_count = prod_next;
                        r0.consumed_count = cons_next;
                        n                 = 2'd1;
                        do_fresh          = 1'b1;
                    end
                end
            end else begin
                do_fresh = 1'b1;
            end

            // The current unit decoded on its own.
            if (do_fresh) begin
                cons_next = sat_inc(cons_next);
                if (u_high) begin
                    if (end_of_buffer) begin
                        stopped_next = 1'b1;
                        scode_next   = STOP_HIGH_AT_END;
                        pend_next    = 1'b0;
                    end else begin
                        pend_next  = 1'b1;
                        phigh_next = code_unit[9:0];
                    end
                end else if (u_low && !ignore_errors) begin
                    stopped_next = 1'b1;
                    scode_next   = STOP_LONE_LOW;
                    pend_next    = 1'b0;
                end else if (lim_on && prod_next >= output_limit) begin
                    stopped_next = 1'b1;
                    scode_next   = STOP_OUTPUT_FULL;
                    pend_next    = 1'b0;
                end else begin
                    prod_next         = sat_inc(prod_next);
                    rn.code_point     = {5'b0, code_unit};
                    rn.has_code_point = 1'b1;
                    rn.produced_count = prod_next;
                    rn.consumed_count = cons_next;
                    if (n == 2'd0) begin
                        r0 = rn;
                    end else begin
                        r1 = rn;
                    end
                    n = n + 2'd1;
                end
            end
        end

        // End of buffer: summary rides on the last result, then state clears.
        if (end_of_buffer) begin
            if (n == 2'd0) begin
                r0 = '0;
                n  = 2'd1;
            end
            if (n == 2'd1) begin
                r0.done_res       = 1'b1;
                r0.stop_reason    = scode_next;
                r0.produced_count = prod_next;
                r0.consumed_count = cons_next;
            end else begin
                r1.done_res       = 1'b1;
                r1.stop_reason    = scode_next;
                r1.produced_count = prod_next;
                r1.consumed_count = cons_next;
            end
            pend_next    = 1'b0;
            phigh_next   = '0;
            stopped_next = 1'b0;
            scode_next   = STOP_NONE;
            prod_next    = '0;
            cons_next    = '0;
        end

        // Mark the last result of the item.
        if (n == 2'd2) begin
            r1.last_of_run = 1'b1;
        end else begin
            r0.last_of_run = 1'b1;
        end
    end

    assign push           = fire && (n != 2'd0);
    assign push_rec.first  = r0;
    assign push_rec.second = r1;
    assign push_rec.two    = (n == 2'd2);

    // Per-buffer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            phigh_reg   <= '0;
            stopped_reg <= 1'b0;
            scode_reg   <= STOP_NONE;
            prod_reg    <= '0;
            cons_reg    <= '0;
        end else if (fire) begin
            pend_reg    <= pend_next;
            phigh_reg   <= phigh_next;
            stopped_reg <= stopped_next;
            scode_reg   <= scode_next;
            prod_reg    <= prod_next;
            cons_reg    <= cons_next;
        end
    end

endmodule

// ===== hw/rtl/utfd_queue.sv =====
// Short queue of result records between the front and back parts.
// Depends on utfd_pkg for the record type and depth.
module utfd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  utfd_pkg::rec_t push_rec,
    input  logic           pop,
    output utfd_pkg::rec_t pop_rec,
    output logic           full,
    output logic           empty
);
    import utfd_pkg::*;

    rec_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = slots_reg[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/utfd_back.sv =====
// Back part: takes records from the queue and sends their results one per
// transfer through a registered output stage. Depends on utfd_pkg.
module utfd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  utfd_pkg::rec_t q_rec,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic           out_ready,
    output logic           out_valid,
    output utfd_pkg::res_t out_res
);
    import utfd_pkg::*;

    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;
    logic sec_valid_reg, sec_valid_next;
    res_t sec_reg, sec_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Refill the output stage from the held second result or the queue.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sec_valid_next = sec_valid_reg;
        sec_next       = sec_reg;
        q_pop          = 1'b0;
        if (slot_free) begin
            if (sec_valid_reg) begin
                out_next       = sec_reg;
                out_valid_next = 1'b1;
                sec_valid_next = 1'b0;
            end else if (!q_empty) begin
                q_pop          = 1'b1;
                out_next       = q_rec.first;
                out_valid_next = 1'b1;
                sec_valid_next = q_rec.two;
                sec_next       = q_rec.second;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Output and second-result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
        out_reg <= out_next;
        sec_reg <= sec_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// ===== hw/rtl/utf16_to_utf32_decoder_top.sv =====
// UTF-16 to UTF-32 stream decoder. The input stream takes one code unit per cycle with
// no gaps needed while the queue has room; the unit is classified and the buffer state
// updated in the cycle it is accepted, so a new unit can follow every cycle unless
// s_tready is low. Each unit yields zero, one or two results, which pass through the
// queue to the output register. The result port sends one result per cycle while
// m_tready is high, so the sustained rate is one unit per cycle except where an item
// yields two results (lenient mode, an unpaired high followed by a unit that decodes),
// which go out as separate transfers; a four-record queue between the classifying front
// and the output stage absorbs such bursts and output stalls. Configuration is written
// over the APB port while idle; the user ensures this, the block does not enforce it.
// Depends on utfd_pkg, utfd_front, utfd_queue, utfd_back and the defines header.
`include "utf16_to_utf32_decoder_top_defines.svh"

module utf16_to_utf32_decoder_top #(
    parameter int MAX_UNITS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // end_of_buffer
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [20:0] code_point, [23:21] stop_reason, [40:24] produced_count,
    // [57:41] consumed_count, [63:58] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [0] has_code_point, [1] done_res
    output logic        m_tlast,   // last_of_run
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import utfd_pkg::*;

    logic        ign_reg;
    logic [16:0] lim_reg;
    logic        cfg_wr, fire;
    logic        q_push, q_pop, q_full, q_empty;
    rec_t        q_in, q_out;
    res_t        res;
    logic        res_valid;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ign_reg <= 1'b0;
            lim_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_IGNORE_ERRORS: ign_reg <= pwdata[0];
                REG_OUTPUT_LIMIT:  lim_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IGNORE_ERRORS: prdata = {31'b0, ign_reg};
            REG_OUTPUT_LIMIT:  prdata = {15'b0, lim_reg};
            default:           prdata = '0;
        endcase
    end

    // Input transfer is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;

    utfd_front #(
        .MAX_UNITS(MAX_UNITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .code_unit     (s_tdata),
        .end_of_buffer (s_tlast),
        .ignore_errors (ign_reg),
        .output_limit  (lim_reg),
        .push          (q_push),
        .push_rec      (q_in)
    );

    utfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_in),
        .pop      (q_pop),
        .pop_rec  (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    utfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rec     (q_out),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_ready (m_tready),
        .out_valid (res_valid),
        .out_res   (res)
    );

    // Result stream packing.
    assign m_tvalid = res_valid;
    assign m_tdata  = {6'b0, res.consumed_count, res.produced_count,
                       res.stop_reason, res.code_point};
    assign m_tuser  = {res.done_res, res.has_code_point};
    assign m_tlast  = res.last_of_run;

    // A result without a code point is always the buffer summary with a zero code point.
    `UTFD_ASSERT_IMPLY(a_no_cp_is_done, m_tvalid && !m_tuser[0],
        m_tuser[1] && (m_tdata[20:0] == 21'd0))
    // The buffer summary is always the last result of its item.
    `UTFD_ASSERT_IMPLY(a_done_is_last, m_tvalid && m_tuser[1], m_tlast)
    // A stop reason shows only on the buffer summary.
    `UTFD_ASSERT_IMPLY(a_stop_only_done, m_tvalid && !m_tuser[1],
        m_tdata[23:21] == STOP_NONE)
    // The front never pushes into a full queue.
    `UTFD_ASSERT_NEVER(a_no_overflow, q_push && q_full)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the UTF-16 to UTF-32 stream decoder.
// Needs utfd_pkg and the utf16_to_utf32_decoder_top RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
    import utfd_pkg::*;

    localparam int COUNT_CAP   = 65536;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    utf16_to_utf32_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] code_unit
        .s_tlast  (s_tlast),   // end_of_buffer
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // [20:0] code_point, [23:21] stop_reason, [40:24] produced_count,
        // [57:41] consumed_count, [63:58] zero
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),   // [0] has_code_point, [1] done_res
        .m_tlast  (m_tlast),   // last_of_run
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Mirror of the configuration registers.
    logic        lenient   = 1'b0;
    logic [16:0] out_limit = '0;

    // Decoder state for the current buffer.
    logic        pair_pending = 1'b0;
    logic [9:0]  pair_high    = '0;
    logic        halted       = 1'b0;
    stop_t       halt_why     = STOP_NONE;
    logic [16:0] points_made  = '0;
    logic [16:0] units_seen   = '0;

    // Results caused by the unit being decoded.
    res_t batch [2];
    int   nres;

    // Code points still owed by the block, oldest first.
    res_t points_due [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bad_count     = 0;
    int cycles        = 0;

    function automatic logic [16:0] bump(logic [16:0] v);
        return (v < COUNT_CAP) ? v + 17'd1 : v;
    endfunction

    function automatic void stop_decoding(stop_t why);
        halted       = 1'b1;
        halt_why     = why;
        pair_pending = 1'b0;
    endfunction

    // Emit one code point unless the output limit is already reached.
    function automatic void put_point(logic [20:0] cp);
        if (nres >= 2 || (out_limit != 0 && points_made >= out_limit)) begin
            stop_decoding(STOP_OUTPUT_FULL);
            return;
        end
        points_made = bump(points_made);
        batch[nres] = '0;
        batch[nres].code_point     = cp;
        batch[nres].has_code_point = 1'b1;
        batch[nres].produced_count = points_made;
        batch[nres].consumed_count = units_seen;
        nres++;
    endfunction

    // A unit looked at with no high surrogate waiting.
    function automatic void take_unit(logic [15:0] cu, logic eob);
        units_seen = bump(units_seen);
        if (cu[15:10] == SUR_HIGH_TAG) begin
            if (eob) begin
                stop_decoding(STOP_HIGH_AT_END);
            end else begin
                pair_pending = 1'b1;
                pair_high    = cu[9:0];
            end
        end else if (cu[15:10] == SUR_LOW_TAG && !lenient) begin
            stop_decoding(STOP_LONE_LOW);
        end else begin
            put_point({5'b0, cu});
        end
    endfunction

    // Work out every result that one accepted unit causes.
    function automatic void decode_unit(logic [15:0] cu, logic eob);
        int last;
        nres     = 0;
        batch[0] = '0;
        batch[1] = '0;
        if (!halted) begin
            if (pair_pending) begin
                if (cu[15:10] == SUR_LOW_TAG) begin
                    units_seen   = bump(units_seen);
                    pair_pending = 1'b0;
                    put_point({1'b0, pair_high, cu[9:0]} + SUPP_BASE);
                end else if (!lenient) begin
                    stop_decoding(STOP_UNPAIRED_HIGH);
                end else begin
                    // Lenient: the lone high goes out as is, then the unit on its own.
                    pair_pending = 1'b0;
                    put_point({5'b0, SUR_HIGH_TAG, pair_high});
                    if (!halted) take_unit(cu, eob);
                end
            end else begin
                take_unit(cu, eob);
            end
        end
        // The end of a buffer reports the totals and clears the buffer state.
        if (eob) begin
            if (nres == 0) nres = 1;
            last = nres - 1;
            batch[last].done_res       = 1'b1;
            batch[last].stop_reason    = halt_why;
            batch[last].produced_count = points_made;
            batch[last].consumed_count = units_seen;
            pair_pending = 1'b0;
            pair_high    = '0;
            halted       = 1'b0;
            halt_why     = STOP_NONE;
            points_made  = '0;
            units_seen   = '0;
        end
        if (nres > 0) batch[nres - 1].last_of_run = 1'b1;
    endfunction

    // Offer one code unit, with random idle cycles first, and record what it owes.
    task automatic push_unit(input logic [15:0] cu, input logic eob,
                             input logic use_want, input res_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cu;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
        decode_unit(cu, eob);
        if (use_want) begin
            points_due.push_back(want);
        end else begin
            for (int i = 0; i < nres; i++) points_due.push_back(batch[i]);
        end
    endtask

    // Stop sending and wait until the block has nothing left in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (points_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write: setup cycle, then access cycle. The caller ends the access.
    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_idx == REG_IGNORE_ERRORS) lenient = value[0];
        else out_limit = value[16:0];
    endtask

    // After the block settles, both registers are written back to back, then the port goes idle.
    task automatic set_mode(input logic ign, input logic [16:0] lim);
        settle();
        write_reg(REG_IGNORE_ERRORS, {31'b0, ign});
        write_reg(REG_OUTPUT_LIMIT, {15'b0, lim});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A code unit outside the surrogate range, with the edges now and then.
    function automatic logic [15:0] plain_unit();
        logic [15:0] v;
        case ($urandom_range(19))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'hD7FF;
            3: v = 16'hE000;
            default: begin
                v = 16'($urandom);
                if (v[15:11] == 5'b11011) v[15] = 1'b0;
            end
        endcase
        return v;
    endfunction

    // One buffer of mostly well-formed text with some broken surrogates and noise.
    task automatic random_buffer(output int sent);
        logic [15:0] units [$];
        int len;
        int kind;
        len = ($urandom_range(14) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
        while (units.size() < len) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                units.push_back(plain_unit());
            end else if (kind < 80) begin
                units.push_back({SUR_HIGH_TAG, 10'($urandom)});
                units.push_back({SUR_LOW_TAG, 10'($urandom)});
            end else if (kind < 88) begin
                units.push_back({SUR_HIGH_TAG, 10'($urandom)});
            end else if (kind < 95) begin
                units.push_back({SUR_LOW_TAG, 10'($urandom)});
            end else begin
                units.push_back(16'($urandom));
            end
        end
        foreach (units[i]) push_unit(units[i], i == units.size() - 1, 1'b0, '0);
        sent = units.size();
    endtask

    task automatic random_phase(input logic ign, input logic [16:0] lim,
                                input int send_pct, input int rx_pct, input int count);
        int sent;
        int total;
        total = 0;
        set_mode(ign, lim);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        while (total < count) begin
            random_buffer(sent);
            total += sent;
        end
    endtask

    // Directed steps; set_cfg rewrites both registers before the step.
    typedef struct {
        logic        set_cfg;
        logic        ign;
        logic [16:0] lim;
        logic [15:0] cu;
        logic        eob;
        logic        typed;
        res_t        want;
    } step_row_t;

    localparam res_t NO_RESULT = '0;

    step_row_t script [25] = '{
        // Plain units at both ends of the range, strict, no limit.
        '{1'b1, 1'b0, 17'd0, 16'h0000, 1'b1, 1'b1,
          '{21'h0, 1'b1, 1'b1, STOP_NONE, 17'd1, 17'd1, 1'b1}},
        '{1'b0, 1'b0, 17'd0, 16'hFFFF, 1'b1, 1'b1,
          '{21'hFFFF, 1'b1, 1'b1, STOP_NONE, 17'd1, 17'd1, 1'b1}},
        // Lowest and highest surrogate pairs.
        '{1'b0, 1'b0, 17'd0, 16'hD800, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'hDC00, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'hDBFF, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'hDFFF, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'h0041, 1'b1, 1'b0, NO_RESULT},
        // High surrogate on the last unit of a buffer.
        '{1'b0, 1'b0, 17'd0, 16'hDBFF, 1'b1, 1'b1,
          '{21'h0, 1'b0, 1'b1, STOP_HIGH_AT_END, 17'd0, 17'd1, 1'b1}},
        // Lone low surrogate, strict.
        '{1'b0, 1'b0, 17'd0, 16'hDC00, 1'b1, 1'b1,
          '{21'h0, 1'b0, 1'b1, STOP_LONE_LOW, 17'd0, 17'd1, 1'b1}},
        // Unpaired high, strict: the rest of the buffer is dropped.
        '{1'b0, 1'b0, 17'd0, 16'hD9AB, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'h0042, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'h0043, 1'b1, 1'b1,
          '{21'h0, 1'b0, 1'b1, STOP_UNPAIRED_HIGH, 17'd0, 17'd1, 1'b1}},
        '{1'b0, 1'b0, 17'd0, 16'h1234, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'hDFFF, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd0, 16'h5555, 1'b1, 1'b1,
          '{21'h0, 1'b0, 1'b1, STOP_LONE_LOW, 17'd1, 17'd2, 1'b1}},
        // Lenient: a lone low passes through.
        '{1'b1, 1'b1, 17'd0, 16'hDC00, 1'b1, 1'b1,
          '{21'hDC00, 1'b1, 1'b1, STOP_NONE, 17'd1, 17'd1, 1'b1}},
        // Lenient: an unpaired high followed by a high at the end of the buffer.
        '{1'b0, 1'b1, 17'd0, 16'hD801, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 17'd0, 16'hD802, 1'b1, 1'b0, NO_RESULT},
        // Lenient with a limit of one: the second code point hits the limit.
        '{1'b1, 1'b1, 17'd1, 16'hD800, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 17'd1, 16'h0041, 1'b1, 1'b0, NO_RESULT},
        // Lenient with a limit of two: two results from one unit, then full.
        '{1'b1, 1'b1, 17'd2, 16'hDABC, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 17'd2, 16'h0030, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 17'd2, 16'hDC05, 1'b1, 1'b0, NO_RESULT},
        // Strict with a limit of one: full on the second unit.
        '{1'b1, 1'b0, 17'd1, 16'h0061, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 17'd1, 16'h0062, 1'b1, 1'b1,
          '{21'h0, 1'b0, 1'b1, STOP_OUTPUT_FULL, 17'd1, 17'd2, 1'b1}}
    };

    // Result side: random back-pressure and comparison with the oldest expectation.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '0;
                got.code_point     = m_tdata[20:0];
                got.stop_reason    = stop_t'(m_tdata[23:21]);
                got.produced_count = m_tdata[40:24];
                got.consumed_count = m_tdata[57:41];
                got.has_code_point = m_tuser[0];
                got.done_res       = m_tuser[1];
                got.last_of_run    = m_tlast;
                if (points_due.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result transfer: cp=%h user=%b last=%b",
                                 got.code_point, m_tuser, m_tlast);
                end else begin
                    want = points_due.pop_front();
                    if (got.code_point != want.code_point
                        || got.has_code_point != want.has_code_point
                        || got.done_res != want.done_res
                        || got.stop_reason != want.stop_reason
                        || got.produced_count != want.produced_count
                        || got.consumed_count != want.consumed_count
                        || got.last_of_run != want.last_of_run) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display({"mismatch: expected cp=%h has=%b done=%b why=%0d",
                                      " prod=%0d cons=%0d last=%b"},
                                     want.code_point, want.has_code_point, want.done_res,
                                     want.stop_reason, want.produced_count,
                                     want.consumed_count, want.last_of_run);
                            $display({"          got      cp=%h has=%b done=%b why=%0d",
                                      " prod=%0d cons=%0d last=%b"},
                                     got.code_point, got.has_code_point, got.done_res,
                                     m_tdata[23:21], got.produced_count,
                                     got.consumed_count, got.last_of_run);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("utf16_to_utf32_decoder_top test failed");
            $finish;
        end
    end

    // Main sequence: reset, directed steps, random phases.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].set_cfg) set_mode(script[i].ign, script[i].lim);
            push_unit(script[i].cu, script[i].eob, script[i].typed, script[i].want);
        end

        random_phase(1'b0, 17'd0, 0, 0, 375);
        random_phase(1'b1, 17'($urandom_range(8, 1)), 73, 0, 375);
        random_phase(1'b0, 17'd65536, 0, 73, 375);
        random_phase(1'b1, 17'd3, 12, 12, 375);

        s_tvalid <= 1'b0;
        while (points_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (bad_count == 0)
            $display("utf16_to_utf32_decoder_top test passed");
        else
            $display("utf16_to_utf32_decoder_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/utfd_pkg.sv
hw/rtl/utfd_front.sv
hw/rtl/utfd_queue.sv
hw/rtl/utfd_back.sv
hw/rtl/utf16_to_utf32_decoder_top.sv
sim/testbench.sv
